/* hdl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types, constants and helpers for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int COEF_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	localparam int ROOT_WIDTH = 32;

	typedef enum logic [1:0] {
		CASE_TWO_REAL = 2'd0,
		CASE_DOUBLE   = 2'd1,
		CASE_COMPLEX  = 2'd2,
		CASE_A_ZERO   = 2'd3
	} root_case_t;

	typedef struct packed {
		root_case_t rcase;
		logic       neg1;
		logic       neg2;
	} qrs_ctl_t;

	localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7fff_ffff;
	localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

	// Applies the sign to a quotient magnitude and clamps it to the root range.
	function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [63:0] mag,
			input logic neg);
		logic [ROOT_WIDTH-1:0] res;
		if (neg) begin
			if (mag > NEG_LIMIT) begin
				res = NEG_LIMIT[ROOT_WIDTH-1:0];
			end else begin
				res = ROOT_WIDTH'(-mag);
			end
		end else begin
			if (mag > POS_LIMIT) begin
				res = POS_LIMIT[ROOT_WIDTH-1:0];
			end else begin
				res = mag[ROOT_WIDTH-1:0];
			end
		end
		return res;
	endfunction

endpackage

/* hdl/qrs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the restoring square root; passes its partial state onward.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
	parameter int RADW = 50,
	parameter int SQN  = 25,
	parameter int REMW = 27,
	parameter int SW   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_i,
	input  logic [SW-1:0]   side_i,
	input  logic [RADW-1:0] rad_i,
	input  logic [REMW-1:0] rem_i,
	input  logic [SQN-1:0]  root_i,
	output logic            v_o,
	output logic [SW-1:0]   side_o,
	output logic [RADW-1:0] rad_o,
	output logic [REMW-1:0] rem_o,
	output logic [SQN-1:0]  root_o
);

	logic            v_q;
	logic [SW-1:0]   side_q;
	logic [RADW-1:0] rad_q;
	logic [REMW-1:0] rem_q;
	logic [SQN-1:0]  root_q;
	logic [REMW+1:0] rem_n;
	logic [REMW+1:0] trial;
	logic            take;

	assign rem_n = {rem_i, rad_i[RADW-1 -: 2]};
	assign trial = (REMW+2)'({root_i, 2'b01});
	assign take  = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			rad_q  <= rad_i << 2;
			rem_q  <= take ? REMW'(rem_n - trial) : REMW'(rem_n);
			root_q <= {root_i[SQN-2:0], take};
		end
	end

	assign v_o    = v_q;
	assign side_o = side_q;
	assign rad_o  = rad_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;

endmodule

/* hdl/qrs_div_cell.sv */
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of two restoring divisions that share a divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
	parameter int NW  = 25,
	parameter int DVW = 17,
	parameter int SW  = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_i,
	input  logic [SW-1:0]  side_i,
	input  logic [DVW-1:0] den_i,
	input  logic [NW-1:0]  num1_i,
	input  logic [NW-1:0]  num2_i,
	input  logic [DVW-1:0] rem1_i,
	input  logic [DVW-1:0] rem2_i,
	input  logic [NW-1:0]  quo1_i,
	input  logic [NW-1:0]  quo2_i,
	output logic           v_o,
	output logic [SW-1:0]  side_o,
	output logic [DVW-1:0] den_o,
	output logic [NW-1:0]  num1_o,
	output logic [NW-1:0]  num2_o,
	output logic [DVW-1:0] rem1_o,
	output logic [DVW-1:0] rem2_o,
	output logic [NW-1:0]  quo1_o,
	output logic [NW-1:0]  quo2_o
);

	logic           v_q;
	logic [SW-1:0]  side_q;
	logic [DVW-1:0] den_q;
	logic [NW-1:0]  num1_q;
	logic [NW-1:0]  num2_q;
	logic [DVW-1:0] rem1_q;
	logic [DVW-1:0] rem2_q;
	logic [NW-1:0]  quo1_q;
	logic [NW-1:0]  quo2_q;
	logic [DVW:0]   rn1;
	logic [DVW:0]   rn2;
	logic           t1;
	logic           t2;

	assign rn1 = {rem1_i, num1_i[NW-1]};
	assign rn2 = {rem2_i, num2_i[NW-1]};
	assign t1  = (rn1 >= {1'b0, den_i});
	assign t2  = (rn2 >= {1'b0, den_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			den_q  <= den_i;
			num1_q <= num1_i << 1;
			num2_q <= num2_i << 1;
			rem1_q <= t1 ? DVW'(rn1 - {1'b0, den_i}) : DVW'(rn1);
			rem2_q <= t2 ? DVW'(rn2 - {1'b0, den_i}) : DVW'(rn2);
			quo1_q <= {quo1_i[NW-2:0], t1};
			quo2_q <= {quo2_i[NW-2:0], t2};
		end
	end

	assign v_o    = v_q;
	assign side_o = side_q;
	assign den_o  = den_q;
	assign num1_o = num1_q;
	assign num2_o = num2_q;
	assign rem1_o = rem1_q;
	assign rem2_o = rem2_q;
	assign quo1_o = quo1_q;
	assign quo2_o = quo2_q;

endmodule

/* hdl/quadratic_root_solver_unit.sv */
// Throughput: one request per cycle while s_tready is high; the square root and
// division cell chains are fully pipelined, one digit per cell.
// A stalled output takes one more result into a skid entry, then the chains hold.
// Reset clears all valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Classifies and solves a*x^2+b*x+c=0 in fixed point through cell chains.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
	parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// coef_a, coef_b, coef_c, zero fill
	input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// root_one, root_two
	output logic [2*qrs_pkg::ROOT_WIDTH-1:0] m_tdata,
	// root_case
	output logic [1:0] m_tuser
);

	localparam int W    = COEF_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DW   = 2*W+3;
	localparam int MW   = 2*W+1;
	localparam int SQN  = W+F+1;
	localparam int RADW = 2*SQN;
	localparam int REMW = SQN+2;
	localparam int NBW  = W+F+1;
	localparam int DVW  = W+1;
	localparam int NW   = W+F+1;
	localparam int NSW  = NW+1;
	localparam int SSW  = 3+NBW+DVW;
	localparam int CW   = $bits(qrs_pkg::qrs_ctl_t);
	localparam int OW   = qrs_pkg::ROOT_WIDTH;

	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign s_tready = en;

	// Stage 1: products.
	logic signed [W-1:0]   a_in, b_in, c_in;
	logic                  v_s1;
	logic signed [2*W-1:0] bb_s1, ac_s1;
	logic signed [W-1:0]   a_s1, b_s1;

	assign a_in = s_tdata[W-1:0];
	assign b_in = s_tdata[2*W-1:W];
	assign c_in = s_tdata[3*W-1:2*W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= b_in * b_in;
			ac_s1 <= a_in * c_in;
			a_s1  <= a_in;
			b_s1  <= b_in;
		end
	end

	// Stage 2: discriminant and classification.
	logic signed [DW-1:0]  disc;
	logic [MW-1:0]         dabs;
	logic [W-1:0]          aabs;
	logic signed [NBW-1:0] bx, nb;
	qrs_pkg::root_case_t   rcase;
	logic                  v_s2;
	logic [RADW-1:0]       rad_s2;
	logic [SSW-1:0]        side_s2;

	assign disc = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	assign dabs = disc[DW-1] ? MW'(-disc) : MW'(disc);
	assign aabs = a_s1[W-1] ? W'(-a_s1) : W'(a_s1);
	assign bx   = NBW'(b_s1);
	assign nb   = -(bx <<< F);

	always_comb begin
		if (a_s1 == '0) begin
			rcase = qrs_pkg::CASE_A_ZERO;
		end else if (disc == '0) begin
			rcase = qrs_pkg::CASE_DOUBLE;
		end else if (disc[DW-1]) begin
			rcase = qrs_pkg::CASE_COMPLEX;
		end else begin
			rcase = qrs_pkg::CASE_TWO_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= RADW'(dabs) << (2*F);
			side_s2 <= {rcase, a_s1[W-1], nb, aabs, 1'b0};
		end
	end

	// Square root chain.
	logic            sq_v    [0:SQN];
	logic [SSW-1:0]  sq_side [0:SQN];
	logic [RADW-1:0] sq_rad  [0:SQN];
	logic [REMW-1:0] sq_rem  [0:SQN];
	logic [SQN-1:0]  sq_root [0:SQN];

	assign sq_v[0]    = v_s2;
	assign sq_side[0] = side_s2;
	assign sq_rad[0]  = rad_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < SQN; i++) begin : g_sqrt
		qrs_sqrt_cell #(.RADW(RADW), .SQN(SQN), .REMW(REMW), .SW(SSW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (sq_v[i]),
			.side_i (sq_side[i]),
			.rad_i  (sq_rad[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.v_o    (sq_v[i+1]),
			.side_o (sq_side[i+1]),
			.rad_o  (sq_rad[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1])
		);
	end

	// Stage 3: numerators, magnitudes and quotient signs.
	qrs_pkg::root_case_t   sq_case;
	logic                  sq_asign;
	logic signed [NBW-1:0] sq_nb;
	logic [DVW-1:0]        sq_den;
	logic signed [NSW-1:0] nbe, se, n1, n2;
	qrs_pkg::qrs_ctl_t     ctl_d;
	logic                  v_s3;
	logic [NW-1:0]         num1_s3, num2_s3;
	logic [DVW-1:0]        den_s3;
	qrs_pkg::qrs_ctl_t     ctl_s3;

	assign sq_case  = qrs_pkg::root_case_t'(sq_side[SQN][SSW-1 -: 2]);
	assign sq_asign = sq_side[SQN][SSW-3];
	assign sq_nb    = sq_side[SQN][DVW +: NBW];
	assign sq_den   = sq_side[SQN][DVW-1:0];
	assign nbe      = NSW'(sq_nb);
	assign se       = signed'(NSW'(sq_root[SQN]));

	always_comb begin
		case (sq_case)
			qrs_pkg::CASE_TWO_REAL: begin
				n1 = nbe + se;
				n2 = nbe - se;
			end
			qrs_pkg::CASE_DOUBLE: begin
				n1 = nbe;
				n2 = nbe;
			end
			qrs_pkg::CASE_COMPLEX: begin
				n1 = nbe;
				n2 = se;
			end
			default: begin
				n1 = '0;
				n2 = '0;
			end
		endcase
		ctl_d.rcase = sq_case;
		ctl_d.neg1  = n1[NSW-1] ^ sq_asign;
		ctl_d.neg2  = (sq_case == qrs_pkg::CASE_COMPLEX) ? 1'b0 : (n2[NSW-1] ^ sq_asign);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v[SQN];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s3 <= n1[NSW-1] ? NW'(-n1) : NW'(n1);
			num2_s3 <= n2[NSW-1] ? NW'(-n2) : NW'(n2);
			den_s3  <= sq_den;
			ctl_s3  <= ctl_d;
		end
	end

	// Division chain.
	logic           dv_v    [0:NW];
	logic [CW-1:0]  dv_side [0:NW];
	logic [DVW-1:0] dv_den  [0:NW];
	logic [NW-1:0]  dv_num1 [0:NW];
	logic [NW-1:0]  dv_num2 [0:NW];
	logic [DVW-1:0] dv_rem1 [0:NW];
	logic [DVW-1:0] dv_rem2 [0:NW];
	logic [NW-1:0]  dv_quo1 [0:NW];
	logic [NW-1:0]  dv_quo2 [0:NW];

	assign dv_v[0]    = v_s3;
	assign dv_side[0] = ctl_s3;
	assign dv_den[0]  = den_s3;
	assign dv_num1[0] = num1_s3;
	assign dv_num2[0] = num2_s3;
	assign dv_rem1[0] = '0;
	assign dv_rem2[0] = '0;
	assign dv_quo1[0] = '0;
	assign dv_quo2[0] = '0;

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(.NW(NW), .DVW(DVW), .SW(CW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (dv_v[j]),
			.side_i (dv_side[j]),
			.den_i  (dv_den[j]),
			.num1_i (dv_num1[j]),
			.num2_i (dv_num2[j]),
			.rem1_i (dv_rem1[j]),
			.rem2_i (dv_rem2[j]),
			.quo1_i (dv_quo1[j]),
			.quo2_i (dv_quo2[j]),
			.v_o    (dv_v[j+1]),
			.side_o (dv_side[j+1]),
			.den_o  (dv_den[j+1]),
			.num1_o (dv_num1[j+1]),
			.num2_o (dv_num2[j+1]),
			.rem1_o (dv_rem1[j+1]),
			.rem2_o (dv_rem2[j+1]),
			.quo1_o (dv_quo1[j+1]),
			.quo2_o (dv_quo2[j+1])
		);
	end

	// Sign, saturation and output stage.
	qrs_pkg::qrs_ctl_t ctl_l;
	logic [OW-1:0]     r1_l, r2_l;
	logic [2*OW+1:0]   res_l;
	logic              out_v_q;
	logic [2*OW+1:0]   out_q, skid_q;

	assign ctl_l = qrs_pkg::qrs_ctl_t'(dv_side[NW]);
	assign r1_l  = (ctl_l.rcase == qrs_pkg::CASE_A_ZERO) ? '0 :
		qrs_pkg::sat_root(64'(dv_quo1[NW]), ctl_l.neg1);
	assign r2_l  = (ctl_l.rcase == qrs_pkg::CASE_A_ZERO) ? '0 :
		qrs_pkg::sat_root(64'(dv_quo2[NW]), ctl_l.neg2);
	assign res_l = {ctl_l.rcase, r2_l, r1_l};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= dv_v[NW];
			end
		end else if (dv_v[NW] && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res_l;
		end else if (dv_v[NW] && en) begin
			skid_q <= res_l;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q[2*OW-1:0];
	assign m_tuser  = out_q[2*OW+1:2*OW];

endmodule

/* hdl/qrs_checker.sv */
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks for the quadratic root solver.
// ----------------------------------------------------------------------------
module qrs_checker #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [2*qrs_pkg::ROOT_WIDTH-1:0] m_tdata,
	input logic [1:0] m_tuser
);

	localparam int OW = qrs_pkg::ROOT_WIDTH;

	a_hold_valid : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result valid dropped before it was taken.");

	a_hold_data : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result changed.");

	a_zero_a : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == qrs_pkg::CASE_A_ZERO |-> m_tdata == '0)
		else $error("Zero leading coefficient gave nonzero roots.");

	a_double : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == qrs_pkg::CASE_DOUBLE |->
		m_tdata[OW-1:0] == m_tdata[2*OW-1:OW])
		else $error("Double root halves differ.");

	a_imag_pos : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == qrs_pkg::CASE_COMPLEX |-> !m_tdata[2*OW-1])
		else $error("Imaginary magnitude is negative.");

endmodule

bind quadratic_root_solver_unit qrs_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qrs_checker (.*);
